FILE: rtl/lcdnw_pkg.sv
// Shared types, constants and the microcode table of the LCD nibble write sequencer.
package lcdnw_pkg;

	localparam int unsigned WaitW = 16;
	localparam int unsigned StrobeW = 8;
	localparam int unsigned StepW = 4;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [WaitW-1:0] PowerUpWaitRst = 16'd40000;
	localparam logic [WaitW-1:0] SettleWaitRst = 16'd50;
	localparam logic [WaitW-1:0] LongCmdWaitRst = 16'd2000;
	localparam logic [StrobeW-1:0] EnableWidthRst = 8'd1;

	localparam logic [WaitW-1:0] WakeFirstWait = 16'd5000;
	localparam logic [WaitW-1:0] WakeNextWait = 16'd150;
	localparam logic [WaitW-1:0] WaitSat = 16'hFFFF;

	localparam logic [StepW-1:0] EntryInit = 4'd0;
	localparam logic [StepW-1:0] EntryByte = 4'd14;

	localparam logic [3:0] ColumnMax = 4'd15;
	localparam logic [7:0] CmdClear = 8'h01;
	localparam logic [7:0] CmdHome = 8'h02;

	typedef enum logic [1:0] {
		REQ_INIT = 2'd0,
		REQ_CMD  = 2'd1,
		REQ_DATA = 2'd2,
		REQ_GOTO = 2'd3
	} req_kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_POWER_UP_WAIT = 8'd0,
		CFG_SETTLE_WAIT   = 8'd1,
		CFG_LONG_CMD_WAIT = 8'd2,
		CFG_ENABLE_WIDTH  = 8'd3
	} cfg_reg_t;

	// byte source for one step
	typedef enum logic {
		SRC_CONST = 1'b0,
		SRC_REQ   = 1'b1
	} src_t;

	// extra wait after the strobe
	typedef enum logic [1:0] {
		EX_NONE  = 2'd0,
		EX_WAKE1 = 2'd1,
		EX_WAKE  = 2'd2,
		EX_LONG  = 2'd3
	} extra_t;

	typedef struct packed {
		src_t        src;
		logic [7:0]  cbyte;
		logic        hi;
		logic        before_pwr;
		extra_t      extra;
		logic        last;
	} ucw_t;

	typedef struct packed {
		logic        load;
		logic        issue;
		ucw_t        word;
	} ctrl_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  value;
		logic [7:0]  column;
		logic [7:0]  row;
	} req_t;

	typedef struct packed {
		logic               reg_select;
		logic [3:0]         nibble;
		logic [WaitW-1:0]   wait_before_us;
		logic [StrobeW-1:0] strobe_width_us;
		logic [WaitW-1:0]   wait_after_us;
		logic               last;
	} rsp_t;

	function automatic ucw_t uc_word(input src_t src, input logic [7:0] cbyte,
			input logic hi, input logic before_pwr, input extra_t extra, input logic last);
		ucw_t w;
		w.src = src;
		w.cbyte = cbyte;
		w.hi = hi;
		w.before_pwr = before_pwr;
		w.extra = extra;
		w.last = last;
		return w;
	endfunction

	// Program: init runs steps 0 to 13, byte requests run 14 and 15.
	function automatic ucw_t ucode(input logic [StepW-1:0] step);
		ucw_t w;
		unique case (step)
			4'd0:  w = uc_word(SRC_CONST, 8'h03, 1'b0, 1'b1, EX_WAKE1, 1'b0);
			4'd1:  w = uc_word(SRC_CONST, 8'h03, 1'b0, 1'b0, EX_WAKE, 1'b0);
			4'd2:  w = uc_word(SRC_CONST, 8'h03, 1'b0, 1'b0, EX_WAKE, 1'b0);
			4'd3:  w = uc_word(SRC_CONST, 8'h02, 1'b0, 1'b0, EX_WAKE, 1'b0);
			4'd4:  w = uc_word(SRC_CONST, 8'h28, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd5:  w = uc_word(SRC_CONST, 8'h28, 1'b0, 1'b0, EX_LONG, 1'b0);
			4'd6:  w = uc_word(SRC_CONST, 8'h08, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd7:  w = uc_word(SRC_CONST, 8'h08, 1'b0, 1'b0, EX_LONG, 1'b0);
			4'd8:  w = uc_word(SRC_CONST, 8'h01, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd9:  w = uc_word(SRC_CONST, 8'h01, 1'b0, 1'b0, EX_LONG, 1'b0);
			4'd10: w = uc_word(SRC_CONST, 8'h06, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd11: w = uc_word(SRC_CONST, 8'h06, 1'b0, 1'b0, EX_LONG, 1'b0);
			4'd12: w = uc_word(SRC_CONST, 8'h0C, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd13: w = uc_word(SRC_CONST, 8'h0C, 1'b0, 1'b0, EX_LONG, 1'b1);
			4'd14: w = uc_word(SRC_REQ, 8'h00, 1'b1, 1'b0, EX_NONE, 1'b0);
			4'd15: w = uc_word(SRC_REQ, 8'h00, 1'b0, 1'b0, EX_LONG, 1'b1);
			default: w = uc_word(SRC_REQ, 8'h00, 1'b0, 1'b0, EX_NONE, 1'b1);
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/lcdnw_useq.sv
// Step counter and microcode fetch for the LCD nibble write sequencer.
module lcdnw_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_type,
	output logic                req_ready,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	output lcdnw_pkg::ctrl_t    ctrl
);
	import lcdnw_pkg::*;

	logic             busy_q;
	logic [StepW-1:0] step_q;
	ucw_t             word;
	logic             load;
	logic             issue;

	assign word = ucode(step_q);
	assign req_ready = !busy_q;
	assign load = req_valid && !busy_q;
	// issue a step whenever the output register is free or being drained
	assign issue = busy_q && (!rsp_valid || rsp_ready);

	assign ctrl.load = load;
	assign ctrl.issue = issue;
	assign ctrl.word = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= EntryInit;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= (req_kind_t'(req_type) == REQ_INIT) ? EntryInit : EntryByte;
		end else if (issue) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/lcdnw_dpath.sv
// Datapath of the LCD nibble write sequencer: request byte, registers and result register.
module lcdnw_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lcdnw_pkg::ctrl_t               ctrl,
	input  lcdnw_pkg::req_t                req,
	input  logic                           cfg_valid,
	input  logic [lcdnw_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lcdnw_pkg::WaitW-1:0]    cfg_data,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output lcdnw_pkg::rsp_t                rsp
);
	import lcdnw_pkg::*;

	logic [WaitW-1:0]   power_up_wait_q;
	logic [WaitW-1:0]   settle_wait_q;
	logic [WaitW-1:0]   long_cmd_wait_q;
	logic [StrobeW-1:0] enable_width_q;

	logic [7:0]         byte_q;
	logic               rs_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [7:0]         req_byte;
	logic [3:0]         col_c;
	logic [7:0]         cur_byte;
	logic               cur_rs;
	logic [WaitW-1:0]   extra;
	logic [WaitW:0]     after_sum;
	rsp_t               next_rsp;

	// byte for the request: go-to clamps the column and picks the line base
	always_comb begin
		col_c = (req.column > {4'd0, ColumnMax}) ? ColumnMax : req.column[3:0];
		unique case (req_kind_t'(req.req_type)) inside
			REQ_GOTO: req_byte = {1'b1, (req.row != 8'd0), 2'b00, col_c};
			REQ_INIT, REQ_CMD, REQ_DATA: req_byte = req.value;
			default: req_byte = req.value;
		endcase
	end

	always_comb begin
		cur_byte = (ctrl.word.src == SRC_REQ) ? byte_q : ctrl.word.cbyte;
		cur_rs = (ctrl.word.src == SRC_REQ) ? rs_q : 1'b0;
		unique case (ctrl.word.extra)
			EX_NONE:  extra = '0;
			EX_WAKE1: extra = WakeFirstWait;
			EX_WAKE:  extra = WakeNextWait;
			EX_LONG:  extra = (!cur_rs && (cur_byte == CmdClear || cur_byte == CmdHome))
				? long_cmd_wait_q : '0;
			default:  extra = '0;
		endcase
		after_sum = {1'b0, settle_wait_q} + {1'b0, extra};
		next_rsp.reg_select = cur_rs;
		next_rsp.nibble = ctrl.word.hi ? cur_byte[7:4] : cur_byte[3:0];
		next_rsp.wait_before_us = ctrl.word.before_pwr ? power_up_wait_q : '0;
		next_rsp.strobe_width_us = enable_width_q;
		next_rsp.wait_after_us = after_sum[WaitW] ? WaitSat : after_sum[WaitW-1:0];
		next_rsp.last = ctrl.word.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_wait_q <= PowerUpWaitRst;
			settle_wait_q <= SettleWaitRst;
			long_cmd_wait_q <= LongCmdWaitRst;
			enable_width_q <= EnableWidthRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POWER_UP_WAIT: power_up_wait_q <= cfg_data;
				CFG_SETTLE_WAIT:   settle_wait_q <= cfg_data;
				CFG_LONG_CMD_WAIT: long_cmd_wait_q <= cfg_data;
				CFG_ENABLE_WIDTH:  enable_width_q <= cfg_data[StrobeW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.issue) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= req_byte;
			rs_q <= (req_kind_t'(req.req_type) == REQ_DATA);
		end
		if (ctrl.issue) begin
			rsp_q <= next_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer.
//
//  channel  signals                               direction  item
//  req      req_valid, req_ready, req             in         one request
//  rsp      rsp_valid, rsp_ready, rsp             out        one nibble write
//  cfg      cfg_valid, cfg_ready, cfg_index/data  in         one register write
//
// A request is loaded into the step counter, then one nibble write issues per cycle while
// the output is taken: init gives 14 items, other requests 2 items; the first item is
// valid once the step counter has issued its first step into the output register.
// A new request is taken the cycle after the last step issues, while that last
// item may still wait in the output register.
// Reset puts the registers at their defaults and empties the output register.
// A stalled output holds the step counter.
module char_lcd_nibble_write_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  lcdnw_pkg::req_t                req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output lcdnw_pkg::rsp_t                rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcdnw_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lcdnw_pkg::WaitW-1:0]    cfg_data
);
	import lcdnw_pkg::*;

	ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	lcdnw_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctrl      (ctrl)
	);

	lcdnw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
